// ===== sv/bpa_pkg.sv =====
package bpa_pkg;

    // default geometry of the bitmap
    localparam int DEF_NUM_PAGES = 4096;
    localparam int DEF_WORD_BITS = 32;

    // width of the page fields on the channels
    localparam int PAGE_W = 12;

    // pages 0 to 2 are never handed out
    localparam int RESERVED_PAGES = 3;

    typedef enum logic
    {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        ST_ALLOCATED = 2'd0,
        ST_NONE_FREE = 2'd1,
        ST_FREED     = 2'd2
    } status_t;

    typedef enum logic [1:0]
    {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

endpackage

// ===== sv/bpa_if.sv =====
interface bpa_req_if;
    import bpa_pkg::*;

    logic              valid;
    logic              ready;
    logic              command;
    logic [PAGE_W-1:0] page_number;

    modport source (output valid, output command, output page_number, input ready);
    modport sink (input valid, input command, input page_number, output ready);
endinterface

interface bpa_rsp_if;
    import bpa_pkg::*;

    logic              valid;
    logic              ready;
    logic [PAGE_W-1:0] granted_page;
    logic [1:0]        status;

    modport source (output valid, output granted_page, output status, input ready);
    modport sink (input valid, input granted_page, input status, output ready);
endinterface

// ===== sv/bpa_bitmap_mem.sv =====
module bpa_bitmap_mem #(
    parameter int WORD_BITS = 32,
    parameter int DEPTH     = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WORD_BITS-1:0]     wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WORD_BITS-1:0]     rd_data
);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;

    // single write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/bpa_word_scan.sv =====
module bpa_word_scan #(
    parameter int WORD_BITS = 32,
    parameter int LAST_BITS = 32
) (
    input  logic [WORD_BITS-1:0]         word,
    input  logic                         is_first,
    input  logic                         is_last,
    output logic                         found,
    output logic [WORD_BITS-1:0]         lowest,
    output logic [$clog2(WORD_BITS)-1:0] bit_idx
);
    import bpa_pkg::*;

    localparam int BW = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] avail;

    // free bits that may be handed out: not reserved, not past the last page
    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
        begin
            avail[j] = ~word[j]
                       & ~(is_first && (j < RESERVED_PAGES))
                       & ~(is_last && (j >= LAST_BITS));
        end
    end

    // isolate the lowest free bit
    assign lowest = avail & (~avail + WORD_BITS'(1));
    assign found  = |avail;

    // one-hot to binary, each output bit an independent or-reduction
    always_comb
    begin
        bit_idx = '0;
        for (int k = 0; k < BW; k++)
        begin
            for (int j = 0; j < WORD_BITS; j++)
            begin
                if (j[k])
                begin
                    bit_idx[k] = bit_idx[k] | lowest[j];
                end
            end
        end
    end

endmodule

// ===== sv/bitmap_page_allocator.sv =====
// bitmap page allocator, first fit
//
// req channel: command (0 allocate, 1 free) and page_number (used by free).
// rsp channel: granted_page and status (0 allocated, 1 no free page,
// 2 page freed), exactly one response transaction per request transaction.
// after reset the bitmap ram is swept once, one word per cycle; req.ready
// stays low meanwhile. the bitmap lives in a single-port-write ram read one
// word per cycle; a small sequencer walks the words and a shared scan unit
// finds the lowest free bit of the word just read. allocate walks the words
// from the first until one has a free bit; free walks them up to the word
// that holds page_number, and a page beyond the bitmap is answered with no
// change.
// one request is in flight at a time: req.ready is high only when idle.
// the response register holds its value while rsp.ready is low, and the
// next request is taken the cycle after the response transaction.
module bitmap_page_allocator #(
    parameter int NUM_PAGES = bpa_pkg::DEF_NUM_PAGES,
    parameter int WORD_BITS = bpa_pkg::DEF_WORD_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    bpa_req_if.sink   req,
    bpa_rsp_if.source rsp
);
    import bpa_pkg::*;

    localparam int NUM_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX      = $clog2(NUM_WORDS);
    localparam int BW        = $clog2(WORD_BITS);
    localparam int LAST_BITS = NUM_PAGES - (NUM_WORDS - 1) * WORD_BITS;
    localparam int PA        = $clog2(NUM_PAGES + WORD_BITS) + 1;
    localparam int PW        = (PA > PAGE_W + 1) ? PA : PAGE_W + 1;

    localparam logic [WIDX-1:0]      LAST_IDX   = WIDX'(NUM_WORDS - 1);
    localparam logic [PW-1:0]        PAGE_LIMIT = PW'(NUM_PAGES);
    localparam logic [PW-1:0]        WORD_STEP  = PW'(WORD_BITS);
    localparam logic [WORD_BITS-1:0] RESV_WORD  =
        (WORD_BITS'(1) << RESERVED_PAGES) - WORD_BITS'(1);

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [PW-1:0]     page_reg, page_next;
    logic [WIDX-1:0]   idx_reg, idx_next;
    logic [PW-1:0]     base_reg, base_next;
    logic [PAGE_W-1:0] granted_reg, granted_next;
    status_t           status_reg, status_next;

    logic                 wr_en;
    logic [WIDX-1:0]      wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic [WIDX-1:0]      rd_addr;
    logic [WORD_BITS-1:0] rd_data;

    logic                 found;
    logic [WORD_BITS-1:0] lowest;
    logic [BW-1:0]        bit_idx;

    logic [PW-1:0]        page_sum;
    logic [PW-1:0]        page_off;
    logic                 in_word;
    logic [WORD_BITS-1:0] free_mask;
    logic                 last_word;

    bpa_bitmap_mem #(
        .WORD_BITS (WORD_BITS),
        .DEPTH     (NUM_WORDS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bpa_word_scan #(
        .WORD_BITS (WORD_BITS),
        .LAST_BITS (LAST_BITS)
    ) u_scan (
        .word     (rd_data),
        .is_first (idx_reg == '0),
        .is_last  (last_word),
        .found    (found),
        .lowest   (lowest),
        .bit_idx  (bit_idx)
    );

    // page arithmetic for the word under test
    assign last_word = (idx_reg == LAST_IDX);
    assign page_sum  = base_reg + PW'(bit_idx);
    assign page_off  = page_reg - base_reg;
    assign in_word   = (page_reg < base_reg + WORD_STEP);
    assign free_mask = WORD_BITS'(1) << page_off[BW-1:0];

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        page_reg    <= page_next;
        base_reg    <= base_next;
        granted_reg <= granted_next;
        status_reg  <= status_next;
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        page_next    = page_reg;
        idx_next     = idx_reg;
        base_next    = base_reg;
        granted_next = granted_reg;
        status_next  = status_reg;
        wr_en        = 1'b0;
        wr_addr      = idx_reg;
        wr_data      = rd_data;
        rd_addr      = '0;

        case (state_reg)
            S_CLEAR:
            begin
                // sweep the ram with the reset image
                wr_en   = 1'b1;
                wr_data = (idx_reg == '0) ? RESV_WORD : '0;
                if (last_word)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + WIDX'(1);
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next  = cmd_t'(req.command);
                    page_next = PW'(req.page_number);
                    idx_next  = '0;
                    base_next = '0;
                    if (req.command == CMD_FREE && PW'(req.page_number) >= PAGE_LIMIT)
                    begin
                        granted_next = '0;
                        status_next  = ST_FREED;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // prefetch the next word while testing this one
                rd_addr = last_word ? '0 : idx_reg + WIDX'(1);
                if (cmd_reg == CMD_ALLOC)
                begin
                    if (found)
                    begin
                        wr_en        = 1'b1;
                        wr_data      = rd_data | lowest;
                        granted_next = page_sum[PAGE_W-1:0];
                        status_next  = ST_ALLOCATED;
                        state_next   = S_DONE;
                    end
                    else if (last_word)
                    begin
                        granted_next = '0;
                        status_next  = ST_NONE_FREE;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        idx_next  = idx_reg + WIDX'(1);
                        base_next = base_reg + WORD_STEP;
                    end
                end
                else
                begin
                    if (in_word || last_word)
                    begin
                        wr_en        = in_word;
                        wr_data      = rd_data & ~free_mask;
                        granted_next = '0;
                        status_next  = ST_FREED;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        idx_next  = idx_reg + WIDX'(1);
                        base_next = base_reg + WORD_STEP;
                    end
                end
            end

            S_DONE:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // channel outputs
    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = (state_reg == S_DONE);
    assign rsp.granted_page = granted_reg;
    assign rsp.status       = status_reg;

    // checks
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !rsp.valid)
        else $error("request taken while a response is pending");

    a_zero_page_unless_granted: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_ALLOCATED |-> rsp.granted_page == '0)
        else $error("nonzero page on a response without a grant");

    a_no_reserved_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (NUM_PAGES <= (1 << PAGE_W)) && rsp.valid && rsp.status == ST_ALLOCATED
        |-> rsp.granted_page >= PAGE_W'(RESERVED_PAGES))
        else $error("reserved page granted");

    a_write_when_working: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> state_reg == S_CLEAR || state_reg == S_SCAN)
        else $error("bitmap written outside a sweep or scan");

    a_scan_leads_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN && last_word |=> state_reg == S_DONE)
        else $error("scan ran past the last word");

endmodule

// ===== dv/bitmap_page_allocator_tb.sv =====
module bitmap_page_allocator_tb;
    import bpa_pkg::*;

    localparam int NUM_PAGES   = DEF_NUM_PAGES;
    localparam int WORD_BITS   = DEF_WORD_BITS;
    localparam int NUM_WORDS   = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int PAGE_MAX    = (1 << PAGE_W) - 1;
    localparam int RAND_ITEMS  = 583;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 200;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int NUM_DIR     = 19;

    typedef struct packed
    {
        logic [PAGE_W-1:0] granted_page;
        status_t           status;
    } page_rsp_t;

    typedef struct packed
    {
        cmd_t              cmd;
        logic [PAGE_W-1:0] page;
        logic              typed;
        logic [PAGE_W-1:0] granted_page;
        status_t           status;
    } dir_row_t;

    logic clk;
    logic rst_n;

    bpa_req_if req_if();
    bpa_rsp_if rsp_if();

    bitmap_page_allocator dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // mirror of the allocation bitmap
    logic [WORD_BITS-1:0] page_map [NUM_WORDS];
    int                   used_pages;

    page_rsp_t pending_rsp_q [$];
    int        err_count;
    int        rsp_count;
    int        cycle_count;
    int        src_idle_pct;
    int        snk_idle_pct;
    bit        held_off;

    // directed transactions, expected response typed in where obvious
    dir_row_t dir_rows [NUM_DIR] = '{
        '{CMD_ALLOC, 12'd0,    1'b1, 12'd3, ST_ALLOCATED},
        '{CMD_ALLOC, 12'hfff,  1'b1, 12'd4, ST_ALLOCATED},
        '{CMD_FREE,  12'd4,    1'b1, 12'd0, ST_FREED},
        '{CMD_ALLOC, 12'd0,    1'b1, 12'd4, ST_ALLOCATED},
        '{CMD_FREE,  12'd4095, 1'b1, 12'd0, ST_FREED},
        '{CMD_FREE,  12'd0,    1'b1, 12'd0, ST_FREED},
        '{CMD_ALLOC, 12'd0,    1'b1, 12'd5, ST_ALLOCATED},
        '{CMD_FREE,  12'd3,    1'b1, 12'd0, ST_FREED},
        '{CMD_FREE,  12'd3,    1'b1, 12'd0, ST_FREED},
        '{CMD_ALLOC, 12'd0,    1'b1, 12'd3, ST_ALLOCATED},
        '{CMD_FREE,  12'd2048, 1'b1, 12'd0, ST_FREED},
        '{CMD_FREE,  12'haaa,  1'b1, 12'd0, ST_FREED},
        '{CMD_FREE,  12'h555,  1'b1, 12'd0, ST_FREED},
        '{CMD_FREE,  12'd1,    1'b1, 12'd0, ST_FREED},
        '{CMD_FREE,  12'd2,    1'b1, 12'd0, ST_FREED},
        '{CMD_ALLOC, 12'h5a5,  1'b1, 12'd6, ST_ALLOCATED},
        '{CMD_ALLOC, 12'd0,    1'b0, 12'd0, ST_ALLOCATED},
        '{CMD_FREE,  12'd31,   1'b1, 12'd0, ST_FREED},
        '{CMD_FREE,  12'd32,   1'b1, 12'd0, ST_FREED}
    };

    // bitmap state after reset: reserved pages in use
    function automatic void reset_page_map();
        int w;
        for (w = 0; w < NUM_WORDS; w++)
        begin
            page_map[w] = '0;
        end
        for (w = 0; w < RESERVED_PAGES; w++)
        begin
            page_map[w / WORD_BITS][w % WORD_BITS] = 1'b1;
        end
        used_pages = 0;
    endfunction

    // first-fit allocate or unchecked free, updates the mirror
    function automatic page_rsp_t predict_page_op(input cmd_t c, input logic [PAGE_W-1:0] pg);
        page_rsp_t r;
        int        p;
        bit        found;
        r.granted_page = '0;
        found = 1'b0;
        if (c == CMD_FREE)
        begin
            r.status = ST_FREED;
            if (int'(pg) < NUM_PAGES)
            begin
                if (int'(pg) >= RESERVED_PAGES && page_map[pg / WORD_BITS][pg % WORD_BITS])
                    used_pages--;
                page_map[pg / WORD_BITS][pg % WORD_BITS] = 1'b0;
            end
        end
        else
        begin
            r.status = ST_NONE_FREE;
            for (p = RESERVED_PAGES; p < NUM_PAGES && !found; p++)
            begin
                if (!page_map[p / WORD_BITS][p % WORD_BITS])
                begin
                    page_map[p / WORD_BITS][p % WORD_BITS] = 1'b1;
                    used_pages++;
                    r.granted_page = p[PAGE_W-1:0];
                    r.status = ST_ALLOCATED;
                    found = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // a page currently in use (any page when none is), searched from a random start
    function automatic logic [PAGE_W-1:0] pick_used_page();
        int start;
        int p;
        int n;
        start = $urandom_range(NUM_PAGES - 1, RESERVED_PAGES);
        if (used_pages == 0)
            return start[PAGE_W-1:0];
        p = start;
        for (n = 0; n < NUM_PAGES && !page_map[p / WORD_BITS][p % WORD_BITS]; n++)
        begin
            p = (p + 1 < NUM_PAGES) ? p + 1 : RESERVED_PAGES;
        end
        return p[PAGE_W-1:0];
    endfunction

    // present one transaction, wait for acceptance, record its expectation
    task automatic offer(input cmd_t c, input logic [PAGE_W-1:0] pg,
                         input logic typed, input page_rsp_t typed_rsp);
        page_rsp_t predicted;
        if ($urandom_range(99) < src_idle_pct)
        begin
            req_if.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        req_if.valid       <= 1'b1;
        req_if.command     <= c;
        req_if.page_number <= pg;
        do
            @(posedge clk);
        while (!req_if.ready);
        predicted = predict_page_op(c, pg);
        pending_rsp_q.push_back(typed ? typed_rsp : predicted);
    endtask

    // mostly allocations and frees of pages in use, some arbitrary frees
    task automatic offer_random(input int alloc_pct);
        int r;
        r = $urandom_range(99);
        if (r < alloc_pct)
            offer(CMD_ALLOC, PAGE_W'($urandom_range(PAGE_MAX, 0)), 1'b0, '0);
        else if (r < 92)
            offer(CMD_FREE, pick_used_page(), 1'b0, '0);
        else
            offer(CMD_FREE, PAGE_W'($urandom_range(PAGE_MAX, 0)), 1'b0, '0);
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("bitmap_page_allocator_tb failed");
                $finish;
            end
        end
    end

    // response side: random ready, one long hold-off, compare against expectations
    initial
    begin
        page_rsp_t exp_rsp;
        rsp_if.ready <= 1'b0;
        rsp_count = 0;
        held_off = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready)
            begin
                rsp_count++;
                if (pending_rsp_q.size() == 0)
                begin
                    $error("response transaction with nothing pending: granted_page %0d status %0d",
                           rsp_if.granted_page, rsp_if.status);
                    err_count++;
                end
                else
                begin
                    exp_rsp = pending_rsp_q.pop_front();
                    if (rsp_if.granted_page !== exp_rsp.granted_page)
                    begin
                        $error("granted_page expected %0d actual %0d",
                               exp_rsp.granted_page, rsp_if.granted_page);
                        err_count++;
                    end
                    if (rsp_if.status !== exp_rsp.status)
                    begin
                        $error("status expected %0d actual %0d",
                               exp_rsp.status, rsp_if.status);
                        err_count++;
                    end
                end
            end
            if (!held_off && rsp_count == HOLD_AT)
            begin
                held_off = 1'b1;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // reset and stimulus
    initial
    begin
        int i;
        page_rsp_t typed_rsp;
        err_count = 0;
        src_idle_pct = 11;
        snk_idle_pct = 84;
        req_if.valid       <= 1'b0;
        req_if.command     <= CMD_ALLOC;
        req_if.page_number <= '0;
        rst_n = 1'b0;
        reset_page_map();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (i = 0; i < NUM_DIR; i++)
        begin
            typed_rsp.granted_page = dir_rows[i].granted_page;
            typed_rsp.status = dir_rows[i].status;
            offer(dir_rows[i].cmd, dir_rows[i].page, dir_rows[i].typed, typed_rsp);
        end

        // sender mostly busy, receiver mostly stalling
        for (i = 0; i < RAND_ITEMS; i++)
            offer_random(60);

        // sender mostly idle, receiver mostly ready
        src_idle_pct = 84;
        snk_idle_pct = 11;
        for (i = 0; i < RAND_ITEMS; i++)
            offer_random(60);

        // no idling: churn allocations and frees back to back
        src_idle_pct = 0;
        snk_idle_pct = 0;
        for (i = 0; i < RAND_ITEMS; i++)
            offer_random(50);

        req_if.valid <= 1'b0;

        // drain and let any stray response show up
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (err_count == 0)
            $display("bitmap_page_allocator_tb passed");
        else
            $display("bitmap_page_allocator_tb failed");
        $finish;
    end

endmodule
